/* sv/pphc_pkg.sv */
// Shared types and constants for the pump pressure hysteresis controller.
`timescale 1ns / 1ps
`default_nettype none

package pphc_pkg;

    // Linear map from the sample sum to pressure in 1/256 psi units.
    localparam int               MAP_GAIN_W = 20;
    localparam logic [19:0]      MAP_GAIN   = 20'd810947;
    localparam int               MAP_SHIFT  = 20;
    localparam int               MAP_OFFSET = 12272;
    localparam logic [7:0]       PSI_MAX    = 8'd150;

    // Pressure word: the mapped value stays within -12272..38411.
    localparam int               P_W        = 17;
    // Threshold compare width: (set +/- deadband) * 256 as signed.
    localparam int               TH_W       = 18;

    // Command queue between the front and the back.
    localparam int               QUEUE_DEPTH = 8;
    localparam int               QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int               QCNT_W      = QPTR_W + 1;

    // Configuration register indexes.
    localparam int               CFG_IDX_W         = 8;
    localparam logic [7:0]       REG_SET_PRESSURE  = 8'd0;
    localparam logic [7:0]       REG_DEADBAND      = 8'd1;
    localparam logic [7:0]       REG_MIN_ON_TICKS  = 8'd2;
    localparam logic [7:0]       REG_MIN_OFF_TICKS = 8'd3;

    typedef enum logic [1:0] {
        SW_NONE = 2'd0,
        SW_ON   = 2'd1,
        SW_OFF  = 2'd2
    } switch_t;

    typedef struct packed {
        logic [7:0] set_pressure;
        logic [7:0] deadband;
        logic [7:0] min_on_ticks;
        logic [7:0] min_off_ticks;
    } cfg_t;

    // One command from the front: a timer tick or a closed reading.
    typedef struct packed {
        logic                  is_tick;
        logic                  low_level;
        logic signed [P_W-1:0] pressure;
        logic [7:0]            psi;
    } op_t;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic       low_level_seen;
        logic       off_hold;
        logic       on_hold;
        logic [7:0] pressure_psi;
        switch_t    switched;
        logic       pump_on;
    } res_t;

endpackage

`default_nettype wire

/* sv/pump_pressure_hysteresis_controller.sv */
// Top level of the pump pressure hysteresis controller.
`timescale 1ns / 1ps
`default_nettype none

// The input stream carries ADC samples (tuser low) and timer ticks (tuser high).
// Every SAMPLES_PER_READING-th sample closes a reading; the samples are summed,
// mapped to pressure, and the hysteresis decision produces one result transfer on
// the output stream. Ticks and the other samples produce no result; a tick counts
// down the minimum-on and minimum-off holds.
// The block takes one input transfer per cycle while s_axis_tready is high. A result
// passes from the sample that closed its reading through the mapping pipeline in the
// front (sum, gain multiply, reciprocal multiply, correction, offset and clamp), then
// through the command queue and the output register.
// Configuration writes are taken at any time, one per cycle, and must only be
// issued while no item is in flight.
// Reset clears the sample accumulator, the pump state and both holds, and loads
// the configuration registers with their defaults (setpoint 100 psi, deadband
// 5 psi, two ticks for each hold). When the receiver stalls, results wait in the
// output register and the command queue; input keeps flowing until the queue and
// pipeline credits run out, then s_axis_tready drops.

module pump_pressure_hysteresis_controller
    import pphc_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 5,
    parameter int HOLD_COUNT_BITS     = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // adc_sample[15:0], low_level[16], zero fill
    input  wire logic        s_axis_tuser,   // action: 0 ADC sample, 1 timer tick
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pump_on[0], switched[2:1], pressure_psi[10:3], on_hold[11], off_hold[12],
    // low_level_seen[13], zero fill
    output logic [15:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cfg_t              cfg_reg;
    logic              cfg_write;

    logic              op_valid;
    op_t               op;
    logic              q_pop;
    logic              head_valid;
    op_t               head;
    logic [QCNT_W-1:0] q_count;
    res_t              res;

    // The configuration port never stalls; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_pressure  <= 8'd100;
            cfg_reg.deadband      <= 8'd5;
            cfg_reg.min_on_ticks  <= 8'd2;
            cfg_reg.min_off_ticks <= 8'd2;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SET_PRESSURE:  cfg_reg.set_pressure  <= cfg_data;
                REG_DEADBAND:      cfg_reg.deadband      <= cfg_data;
                REG_MIN_ON_TICKS:  cfg_reg.min_on_ticks  <= cfg_data;
                REG_MIN_OFF_TICKS: cfg_reg.min_off_ticks <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Front: accumulation and pressure mapping, with credits that keep the
    // queue from overflowing.
    pphc_front #(
        .SAMPLES_PER_READING(SAMPLES_PER_READING)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_action(s_axis_tuser),
        .in_sample(s_axis_tdata[15:0]),
        .in_low   (s_axis_tdata[16]),
        .pop      (q_pop),
        .op_valid (op_valid),
        .op       (op)
    );

    // Ticks and readings keep their order through the queue, so a hold always
    // sees the ticks that arrived before its reading.
    pphc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_valid),
        .push_data (op),
        .pop       (q_pop),
        .head_valid(head_valid),
        .head      (head),
        .count     (q_count)
    );

    // Back: decision, holds and the result register.
    pphc_back #(
        .HOLD_COUNT_BITS(HOLD_COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_valid(head_valid),
        .head      (head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {2'b00, res};

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue holds more entries than its depth");

    a_on_drives_pump: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.switched == SW_ON) |-> res.pump_on)
        else $error("turn-on result with the pump off");

    a_off_stops_pump: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.switched == SW_OFF) |-> !res.pump_on && res.off_hold
            || cfg_reg.min_off_ticks == 8'd0)
        else $error("turn-off result with the pump on or no off hold");

    a_on_hold_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (res.switched == SW_ON) && (cfg_reg.min_on_ticks != 8'd0)
            |-> res.on_hold)
        else $error("turn-on result without an active on hold");
`endif

endmodule

`default_nettype wire

/* sv/pphc_front.sv */
// Front part: accepts items, accumulates samples and maps each reading to pressure.
`timescale 1ns / 1ps
`default_nettype none

module pphc_front
    import pphc_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 5
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic in_action,
    input  wire logic [15:0] in_sample,
    input  wire logic in_low,
    input  wire logic pop,
    output logic      op_valid,
    output op_t       op
);

    localparam int SUM_W = 16 + $clog2(SAMPLES_PER_READING);
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);
    // Reciprocal of the sample count, exact to within one in the quotient.
    localparam int RK = SUM_W + 1;
    localparam logic [RK:0] RECIP = (RK + 1)'((64'd1 << RK) / SAMPLES_PER_READING);
    localparam int GP_W = SUM_W + MAP_GAIN_W;
    localparam int RP_W = SUM_W + RK + 1;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [QCNT_W-1:0] credit_reg, credit_next;

    logic              a_valid_reg, a_tick_reg, a_low_reg;
    logic [SUM_W-1:0]  a_sum_reg;
    logic              b_valid_reg, b_tick_reg, b_low_reg;
    logic [SUM_W-1:0]  b_q_reg;
    logic              c_valid_reg, c_tick_reg, c_low_reg;
    logic [SUM_W-1:0]  c_q_reg;
    logic [RP_W-1:0]   c_prod_reg;
    logic              d_valid_reg, d_tick_reg, d_low_reg;
    logic [SUM_W-1:0]  d_quot_reg;
    logic              op_valid_reg;
    op_t               op_reg, op_next;

    logic              accept, close_rd, issue;
    logic [SUM_W-1:0]  sum_add;
    logic [GP_W-1:0]   gain_prod;
    logic [SUM_W-1:0]  est, rem, quot;
    logic signed [SUM_W:0]   p_wide;
    logic signed [P_W-1:0]   p_val;
    logic [P_W-9:0]    p_int;

    assign in_ready = credit_reg < QCNT_W'(QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;
    assign close_rd = accept && !in_action && (cnt_reg == LAST_CNT);
    assign issue    = accept && (in_action || close_rd);
    assign sum_add  = sum_reg + SUM_W'(in_sample);

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (accept && !in_action)
        begin
            if (close_rd)
            begin
                cnt_next = '0;
                sum_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                sum_next = sum_add;
            end
        end
    end

    // Credits cover every command in the pipeline or the queue.
    always_comb
    begin
        case ({issue, pop})
            2'b10:   credit_next = credit_reg + QCNT_W'(1);
            2'b01:   credit_next = credit_reg - QCNT_W'(1);
            default: credit_next = credit_reg;
        endcase
    end

    assign gain_prod = GP_W'(a_sum_reg) * GP_W'(MAP_GAIN);

    // Quotient estimate is at most one low; one compare fixes it.
    assign est  = c_prod_reg[RK +: SUM_W];
    assign rem  = c_q_reg - SUM_W'(est * SUM_W'(SAMPLES_PER_READING));
    assign quot = (rem >= SUM_W'(SAMPLES_PER_READING)) ? est + SUM_W'(1) : est;

    assign p_wide = $signed({1'b0, d_quot_reg}) - $signed((SUM_W + 1)'(MAP_OFFSET));
    assign p_val  = p_wide[P_W-1:0];
    assign p_int  = p_val[P_W-1:8];

    always_comb
    begin
        op_next.is_tick   = d_tick_reg;
        op_next.low_level = d_low_reg;
        op_next.pressure  = p_val;
        if (p_val <= 0)
        begin
            op_next.psi = '0;
        end
        else if (p_int > {1'b0, PSI_MAX})
        begin
            op_next.psi = PSI_MAX;
        end
        else
        begin
            op_next.psi = p_int[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            sum_reg      <= '0;
            credit_reg   <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            op_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            credit_reg   <= credit_next;
            a_valid_reg  <= issue;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= c_valid_reg;
            op_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tick_reg <= in_action;
        a_low_reg  <= in_low;
        a_sum_reg  <= sum_add;
        b_tick_reg <= a_tick_reg;
        b_low_reg  <= a_low_reg;
        b_q_reg    <= gain_prod[MAP_SHIFT +: SUM_W];
        c_tick_reg <= b_tick_reg;
        c_low_reg  <= b_low_reg;
        c_q_reg    <= b_q_reg;
        c_prod_reg <= RP_W'(b_q_reg) * RP_W'(RECIP);
        d_tick_reg <= c_tick_reg;
        d_low_reg  <= c_low_reg;
        d_quot_reg <= quot;
        op_reg     <= op_next;
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

/* sv/pphc_fifo.sv */
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module pphc_fifo
    import pphc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_data,
    input  wire logic pop,
    output logic      head_valid,
    output op_t       head,
    output logic [QCNT_W-1:0] count
);

    op_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

/* sv/pphc_back.sv */
// Back part: hysteresis decision, hold counters and the output register.
`timescale 1ns / 1ps
`default_nettype none

module pphc_back
    import pphc_pkg::*;
#(
    parameter int HOLD_COUNT_BITS = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic head_valid,
    input  op_t       head,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    localparam int LW = (HOLD_COUNT_BITS > 8) ? HOLD_COUNT_BITS : 8;

    function automatic logic [HOLD_COUNT_BITS-1:0] hold_load(input logic [7:0] ticks);
        logic [LW-1:0] t;
        logic [LW-1:0] m;
        t = LW'(ticks);
        m = LW'((1 << HOLD_COUNT_BITS) - 1);
        hold_load = (t > m) ? HOLD_COUNT_BITS'(m) : HOLD_COUNT_BITS'(t);
    endfunction

    logic                       run_reg, run_next;
    logic [HOLD_COUNT_BITS-1:0] on_cnt_reg, on_cnt_next;
    logic [HOLD_COUNT_BITS-1:0] off_cnt_reg, off_cnt_next;
    logic                       out_valid_reg, out_valid_next;
    res_t                       res_reg, res_next;

    logic [9:0]                 lo_diff;
    logic [8:0]                 hi_sum;
    logic signed [TH_W-1:0]     lo_th, hi_th, p_ext;
    logic                       start, stop, take_rd;
    switch_t                    sw;

    assign pop     = head_valid && (head.is_tick || !out_valid_reg || out_ready);
    assign take_rd = pop && !head.is_tick;

    assign lo_diff = {2'b00, cfg.set_pressure} - {2'b00, cfg.deadband};
    assign hi_sum  = {1'b0, cfg.set_pressure} + {1'b0, cfg.deadband};
    assign lo_th   = $signed({lo_diff, 8'b0});
    assign hi_th   = $signed({1'b0, hi_sum, 8'b0});
    assign p_ext   = $signed({{(TH_W - P_W){head.pressure[P_W-1]}}, head.pressure});

    // Start and stop can never both hold: the low threshold never exceeds the high one.
    assign start = (p_ext < lo_th) && !run_reg && (off_cnt_reg == '0) && !head.low_level;
    assign stop  = (p_ext >= hi_th) && run_reg && (on_cnt_reg == '0);

    always_comb
    begin
        run_next     = run_reg;
        on_cnt_next  = on_cnt_reg;
        off_cnt_next = off_cnt_reg;
        sw           = SW_NONE;
        if (pop && head.is_tick)
        begin
            if (on_cnt_reg != '0)
            begin
                on_cnt_next = on_cnt_reg - HOLD_COUNT_BITS'(1);
            end
            if (off_cnt_reg != '0)
            begin
                off_cnt_next = off_cnt_reg - HOLD_COUNT_BITS'(1);
            end
        end
        else if (take_rd)
        begin
            if (start)
            begin
                run_next    = 1'b1;
                on_cnt_next = hold_load(cfg.min_on_ticks);
                sw          = SW_ON;
            end
            else if (stop)
            begin
                run_next     = 1'b0;
                off_cnt_next = hold_load(cfg.min_off_ticks);
                sw           = SW_OFF;
            end
        end
    end

    always_comb
    begin
        res_next.pump_on        = run_next;
        res_next.switched       = sw;
        res_next.pressure_psi   = head.psi;
        res_next.on_hold        = on_cnt_next != '0;
        res_next.off_hold       = off_cnt_next != '0;
        res_next.low_level_seen = head.low_level;
        if (take_rd)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            on_cnt_reg    <= '0;
            off_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            on_cnt_reg    <= on_cnt_next;
            off_cnt_reg   <= off_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_rd)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* tb/tb_pump_pressure_hysteresis_controller.sv */
// Self-checking stream testbench for the pump pressure hysteresis controller.
`timescale 1ns / 1ps

module tb_pump_pressure_hysteresis_controller;
    import pphc_pkg::*;

    // Block configuration and the pressure map that the predictor uses.
    localparam int          SAMPLES       = 5;
    localparam int          HOLD_BITS     = 8;
    localparam longint      PRESS_GAIN    = 810947;
    localparam longint      PRESS_DIV     = longint'(SAMPLES) << 20;
    localparam longint      PRESS_OFFSET  = 12272;
    localparam longint      PRESS_LIMIT   = 512 * 256;
    localparam int unsigned FULL_SUM      = SAMPLES * 65535;
    localparam int          PSI_CEILING   = 150;

    // Run control.
    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          REPORT_LIMIT  = 10;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // adc_sample[15:0], low_level[16], zero fill
    logic                 s_axis_tuser  = 1'b0; // action: 0 ADC sample, 1 timer tick
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // pump_on[0], switched[2:1], pressure_psi[10:3], on_hold[11], off_hold[12],
    // low_level_seen[13], zero fill
    logic [15:0]          m_axis_tdata;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]           cfg_data      = '0;

    // When set, neither the sender nor the receiver inserts idle cycles.
    bit steady_flow = 1'b0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Predictor copy of the registers and the controller state.
    logic [7:0]           set_psi;
    logic [7:0]           band_psi;
    logic [7:0]           min_on_cfg;
    logic [7:0]           min_off_cfg;
    int unsigned          acc_sum;
    int                   acc_count;
    logic                 pump_running;
    logic [HOLD_BITS-1:0] on_hold_left;
    logic [HOLD_BITS-1:0] off_hold_left;

    // Expected readings, oldest first.
    res_t pending_readings[$];

    res_t got_reading;
    res_t want_reading;
    logic field_bad;

    always #10 clk = ~clk;

    pump_pressure_hysteresis_controller #(
        .SAMPLES_PER_READING (SAMPLES),
        .HOLD_COUNT_BITS     (HOLD_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Advances the predictor by one accepted input transfer. Returns 1 and the
    // expected reading when the transfer closes a reading, 0 otherwise.
    function automatic bit predict_transfer(input logic tick, input logic [15:0] adc,
                                            input logic low, output res_t r);
        longint  p;
        longint  lo_th;
        longint  hi_th;
        switch_t sw;
        r = '0;
        // A tick only counts both holds down; its data fields mean nothing.
        if (tick)
        begin
            if (on_hold_left != 0)
                on_hold_left--;
            if (off_hold_left != 0)
                off_hold_left--;
            return 1'b0;
        end
        acc_sum += adc;
        acc_count++;
        if (acc_count < SAMPLES)
            return 1'b0;

        // Sum to pressure in 1/256 psi, floor division before the offset.
        p = (longint'(acc_sum) * PRESS_GAIN) / PRESS_DIV - PRESS_OFFSET;
        if (p > PRESS_LIMIT)
            p = PRESS_LIMIT;
        if (p < -PRESS_LIMIT)
            p = -PRESS_LIMIT;
        acc_sum   = 0;
        acc_count = 0;

        // Thresholds are signed, so a negative lower threshold stays below zero.
        lo_th = (longint'(set_psi) - longint'(band_psi)) * 256;
        hi_th = (longint'(set_psi) + longint'(band_psi)) * 256;
        sw    = SW_NONE;
        // The start test comes first; the hold it loads blocks a stop in the
        // same reading. Register values fit the hold counters without saturation.
        if (p < lo_th && !pump_running && off_hold_left == 0 && !low)
        begin
            pump_running = 1'b1;
            on_hold_left = min_on_cfg;
            sw           = SW_ON;
        end
        if (p >= hi_th && pump_running && on_hold_left == 0)
        begin
            pump_running  = 1'b0;
            off_hold_left = min_off_cfg;
            sw            = SW_OFF;
        end

        r.pump_on        = pump_running;
        r.switched       = sw;
        if (p <= 0)
            r.pressure_psi = 8'd0;
        else if ((p >>> 8) > PSI_CEILING)
            r.pressure_psi = 8'(PSI_CEILING);
        else
            r.pressure_psi = 8'(p >>> 8);
        r.on_hold        = (on_hold_left != 0);
        r.off_hold       = (off_hold_left != 0);
        r.low_level_seen = low;
        return 1'b1;
    endfunction

    // Smallest five-sample sum whose mapped pressure reaches the target.
    function automatic int unsigned sum_for_pressure(input longint target);
        longint need;
        need = target + PRESS_OFFSET;
        if (need <= 0)
            return 0;
        need = (need * PRESS_DIV + PRESS_GAIN - 1) / PRESS_GAIN;
        if (need > FULL_SUM)
            return FULL_SUM;
        return int'(need);
    endfunction

    // Sends one input transfer, idling first at random. The valid stays high
    // after acceptance so that back-to-back transfers need no extra edge.
    task automatic send_item(input logic tick, input logic [15:0] adc, input logic low);
        int   gap;
        res_t r;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(99) < 35)
                gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, low, adc};
        s_axis_tuser  <= tick;
        // Ready is taken as it stood at the edge itself.
        @(posedge clk iff s_axis_tready);
        if (predict_transfer(tick, adc, low, r))
            pending_readings.push_back(r);
    endtask

    // Sends five samples that add up to the given sum, each optionally
    // scattered by a random offset. Only the closing sample's low level counts.
    task automatic send_reading(input int unsigned sum, input logic low, input int jitter);
        int unsigned base;
        int unsigned rem;
        int          s;
        logic        l;
        base = sum / SAMPLES;
        rem  = sum % SAMPLES;
        for (int i = 0; i < SAMPLES; i++)
        begin
            s = int'(base) + ((i < rem) ? 1 : 0);
            if (jitter != 0)
                s += int'($urandom_range(2 * jitter)) - jitter;
            if (s < 0)
                s = 0;
            else if (s > 65535)
                s = 65535;
            l = (i == SAMPLES - 1) ? low : 1'($urandom_range(1));
            send_item(1'b0, s[15:0], l);
        end
    endtask

    // Stops the sender, waits for every expected reading and lets the last
    // ticks run through the pipeline so the block is idle.
    task automatic wait_idle;
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the valid is left high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SET_PRESSURE:  set_psi     = val;
            REG_DEADBAND:      band_psi    = val;
            REG_MIN_ON_TICKS:  min_on_cfg  = val;
            REG_MIN_OFF_TICKS: min_off_cfg = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] set_v, input logic [7:0] band_v,
                              input logic [7:0] on_v, input logic [7:0] off_v);
        write_reg(REG_SET_PRESSURE, set_v);
        write_reg(REG_DEADBAND, band_v);
        write_reg(REG_MIN_ON_TICKS, on_v);
        write_reg(REG_MIN_OFF_TICKS, off_v);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic. Most of it is whole readings aimed around the current
    // thresholds so that the pump actually cycles; the rest is ticks, tick
    // runs that let long holds expire, full-range readings and stray samples
    // that shift the reading boundaries.
    task automatic run_random_phase(input int items);
        int     sent;
        int     pick;
        int     run;
        longint lo_th;
        longint hi_th;
        longint target;
        int unsigned sum;
        logic   low;
        sent = 0;
        while (sent < items)
        begin
            pick  = $urandom_range(99);
            lo_th = (longint'(set_psi) - longint'(band_psi)) * 256;
            hi_th = (longint'(set_psi) + longint'(band_psi)) * 256;
            low   = ($urandom_range(7) == 0);
            if (pick < 16)
            begin
                send_item(1'b1, 16'($urandom_range(65535)), 1'($urandom_range(1)));
                sent++;
            end
            else if (pick < 20)
            begin
                run = $urandom_range(40, 1);
                repeat (run)
                    send_item(1'b1, 16'($urandom_range(65535)), 1'($urandom_range(1)));
                sent += run;
            end
            else if (pick < 84)
            begin
                // Within about eight psi of either threshold.
                target = ((pick & 1) ? lo_th : hi_th) + longint'($urandom_range(4096)) - 2048;
                send_reading(sum_for_pressure(target), low,
                             $urandom_range(1) ? 0 : int'($urandom_range(80)));
                sent += SAMPLES;
            end
            else if (pick < 92)
            begin
                // Exactly on a threshold or one step below it.
                sum = sum_for_pressure($urandom_range(1) ? lo_th : hi_th);
                if (sum != 0 && $urandom_range(1))
                    sum--;
                send_reading(sum, low, 0);
                sent += SAMPLES;
            end
            else if (pick < 96)
            begin
                send_reading($urandom_range(FULL_SUM), low, 2000);
                sent += SAMPLES;
            end
            else
            begin
                send_item(1'b0, 16'($urandom_range(65535)), 1'($urandom_range(1)));
                sent++;
            end
        end
        wait_idle();
    endtask

    // Directed walk through the hysteresis at the reset configuration:
    // threshold edges, the low-level lockout, both holds, zero and full scale.
    task automatic test_reset_walkthrough;
        longint lo_th;
        longint hi_th;
        lo_th = (longint'(set_psi) - longint'(band_psi)) * 256;
        hi_th = (longint'(set_psi) + longint'(band_psi)) * 256;
        // Exactly at the lower threshold the pump stays off.
        send_reading(sum_for_pressure(lo_th), 1'b0, 0);
        // Negative pressure reports zero psi; the low-level switch blocks a start.
        send_reading(0, 1'b1, 0);
        // One step below the lower threshold starts the pump and its on hold.
        send_reading(sum_for_pressure(lo_th) - 1, 1'b0, 0);
        // Full scale clamps to the top of the range; the on hold blocks a stop.
        send_reading(FULL_SUM, 1'b1, 0);
        // Two ticks expire the default on hold; tick data is don't-care.
        send_item(1'b1, 16'hFFFF, 1'b1);
        send_item(1'b1, 16'h0000, 1'b0);
        // At the upper threshold the pump stops and the off hold begins.
        send_reading(sum_for_pressure(hi_th), 1'b0, 0);
        // Low pressure during the off hold must not restart the pump.
        send_reading(0, 1'b0, 0);
        wait_idle();
    endtask

    // Register extremes: both thresholds at zero, thresholds out of reach,
    // a lower threshold below zero, and the shortest and longest holds.
    task automatic test_register_corners;
        set_config(8'd0, 8'd0, 8'd1, 8'd1);
        run_random_phase(60);
        set_config(8'd255, 8'd255, 8'd255, 8'd255);
        run_random_phase(60);
        set_config(8'd0, 8'd255, 8'd255, 8'd1);
        run_random_phase(60);
        set_config(8'd255, 8'd0, 8'd1, 8'd255);
        run_random_phase(60);
        set_config(8'd150, 8'd0, 8'd1, 8'd1);
        run_random_phase(60);
    endtask

    // Back-to-back transfers on both streams with no idling at all.
    task automatic test_steady_stream;
        set_config(8'd60, 8'd3, 8'd2, 8'd3);
        steady_flow = 1'b1;
        run_random_phase(150);
        steady_flow = 1'b0;
    endtask

    // Random settings, mostly with thresholds inside the measurable range.
    task automatic test_random_settings;
        for (int k = 0; k < 5; k++)
        begin
            if (k == 4)
                set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
            else
                set_config(8'($urandom_range(140, 20)), 8'($urandom_range(20)),
                           8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)));
            run_random_phase(130);
        end
    endtask

    // The receiver stalls at random unless the stream is meant to run steady.
    always @(posedge clk)
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 35);

    // Result checker: every result transfer is matched against the oldest
    // expected reading, one field at a time.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_reading = res_t'(m_axis_tdata[13:0]);
            if (pending_readings.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: result with no reading pending, tdata=%h",
                             $realtime, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want_reading = pending_readings.pop_front();
                field_bad = (got_reading.pump_on        !== want_reading.pump_on)
                         || (got_reading.switched       !== want_reading.switched)
                         || (got_reading.pressure_psi   !== want_reading.pressure_psi)
                         || (got_reading.on_hold        !== want_reading.on_hold)
                         || (got_reading.off_hold       !== want_reading.off_hold)
                         || (got_reading.low_level_seen !== want_reading.low_level_seen)
                         || (m_axis_tdata[15:14]        !== 2'b00);
                if (field_bad)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: reading mismatch, expected pump=%0d sw=%0d psi=%0d ",
                                 $realtime, want_reading.pump_on, want_reading.switched,
                                 want_reading.pressure_psi,
                                 "on_hold=%0d off_hold=%0d low=%0d, ",
                                 want_reading.on_hold, want_reading.off_hold,
                                 want_reading.low_level_seen,
                                 "got pump=%0b sw=%0d psi=%0d ",
                                 got_reading.pump_on, got_reading.switched,
                                 got_reading.pressure_psi,
                                 "on_hold=%0b off_hold=%0b low=%0b fill=%b",
                                 got_reading.on_hold, got_reading.off_hold,
                                 got_reading.low_level_seen, m_axis_tdata[15:14]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: the run ends if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        // Predictor state after reset: default registers, pump off, no holds.
        set_psi       = 8'd100;
        band_psi      = 8'd5;
        min_on_cfg    = 8'd2;
        min_off_cfg   = 8'd2;
        acc_sum       = 0;
        acc_count     = 0;
        pump_running  = 1'b0;
        on_hold_left  = '0;
        off_hold_left = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_walkthrough();
        test_register_corners();
        test_steady_stream();
        test_random_settings();

        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
